// ===== design/cts_pkg.sv =====
// shared constants and field widths for the cosine top-k search block
// no dependencies
package cts_pkg;

    localparam int N_DOCS = 256;
    localparam int DIM    = 64;
    localparam int K_MAX  = 64;

    localparam int SLOT_W = $clog2(N_DOCS);
    localparam int CNT_W  = $clog2(N_DOCS + 1);
    localparam int IDX_W  = $clog2(DIM);
    localparam int IDXC_W = $clog2(DIM + 1);
    localparam int VEC_AW = SLOT_W + IDX_W;

    localparam int ID_W   = 31;
    localparam int VAL_W  = 16;
    localparam int RANK_W = 6;
    localparam int STAT_W = 2;
    localparam int KW     = 7;

    localparam logic [STAT_W-1:0] ST_MATCH = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [KW-1:0] TOPK_RESET = 7'd10;

    // arithmetic widths
    localparam int PROD_W   = 2 * VAL_W;
    localparam int NRM_W    = 2 * VAL_W - 2 + IDX_W + 1;
    localparam int DOT_W    = NRM_W + 1;
    localparam int MAG_W    = DOT_W - 1;
    localparam int SQ_SHIFT = 22;
    localparam int SQ_W     = NRM_W + SQ_SHIFT + 1;
    localparam int SQ_TOP   = ((NRM_W + SQ_SHIFT - 1) / 2) * 2;
    localparam int SQ_STEPS = SQ_TOP / 2 + 1;
    localparam int RT_W     = SQ_STEPS;
    localparam int D_W      = 2 * RT_W;
    localparam int FRAC_SH  = 38;
    localparam int DIV_STEPS = 20;
    localparam int Q_W      = DIV_STEPS;
    localparam int CYC_W    = 5;

endpackage

// ===== design/cts_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module cts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/cosine_top_k_vector_search_unit.sv =====
// top level of the cosine top-k search block: sequencer, shared mac,
// shared isqrt / divider and the ranking sweep
// depends on cts_pkg and cts_ram
//
// channel   dir  beat contents
// s_axis    in   tdata{value,elem_index,doc_id} tuser kind tlast last_elem
// m_axis    out  tdata{rank,score,result_id} tuser status tlast last_result
// cfg       in   cfg_data = top_k
//
// a non-last element beat leaves the block in idle, where s_axis_tready is high
// an add commit sweeps the 256 id slots, then copies 64 elements or reports full
// a query runs a 64-element norm pass and its isqrt, then per stored vector a
// 64-element mac, a 30-step isqrt, one multiply and a 20-step divide, then one
// 256-slot sweep per returned rank; the shared units set the rate
// reset clears the slot valid bits, count, buffer valid bits and sets top_k 10
// m_axis stalls hold the block in the emit state; cfg_ready is always high
module cosine_top_k_vector_search_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // doc_id[30:0], elem_index[36:31], value[52:37]
    input  logic        s_axis_tuser,   // kind
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // result_id[30:0], score[46:31], rank[52:47]
    output logic [cts_pkg::STAT_W-1:0] m_axis_tuser,   // status
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [cts_pkg::KW-1:0] cfg_data
);
    import cts_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_FIND = 13'b0000000000010,
        S_COPY = 13'b0000000000100,
        S_NQ   = 13'b0000000001000,
        S_RA   = 13'b0000000010000,
        S_NEXT = 13'b0000000100000,
        S_MAC  = 13'b0000001000000,
        S_RB   = 13'b0000010000000,
        S_MUL  = 13'b0000100000000,
        S_DIV  = 13'b0001000000000,
        S_WSC  = 13'b0010000000000,
        S_SEL  = 13'b0100000000000,
        S_EMIT = 13'b1000000000000
    } state_t;

    state_t state_reg;

    // input beat fields
    logic [ID_W-1:0]         in_id;
    logic [IDX_W-1:0]        in_idx;
    logic signed [VAL_W-1:0] in_val;
    logic                    in_acc;

    assign in_id  = s_axis_tdata[30:0];
    assign in_idx = s_axis_tdata[36:31];
    assign in_val = s_axis_tdata[52:37];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc = s_axis_tvalid & s_axis_tready;
    assign cfg_ready = 1'b1;

    // control and datapath registers
    logic [KW-1:0]     top_k_reg;
    logic [N_DOCS-1:0] slot_valid_reg;
    logic [N_DOCS-1:0] taken_reg;
    logic [DIM-1:0]    av_reg;
    logic [DIM-1:0]    qv_reg;
    logic [CNT_W-1:0]  stored_count_reg;
    logic [CNT_W-1:0]  slot_reg;
    logic [IDXC_W-1:0] idx_reg;
    logic [KW-1:0]     rank_reg;
    logic [CYC_W-1:0]  cyc_reg;

    logic [ID_W-1:0]   pend_id_reg;
    logic              hit_found_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] tgt_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic              f_vld_reg;
    logic [SLOT_W-1:0] f_slot_reg;

    logic              c_vld_reg;
    logic [IDX_W-1:0]  c_idx_reg;
    logic              bufv_d_reg;

    logic              m1_vld_reg;
    logic              m2_vld_reg;
    logic signed [PROD_W-1:0] prod_ab_reg;
    logic signed [PROD_W-1:0] prod_bb_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic [NRM_W-1:0]  nrm_reg;
    logic              nq_zero_reg;
    logic              nv_zero_reg;

    logic [SQ_W-1:0]   sq_x_reg;
    logic [SQ_W-1:0]   sq_r_reg;
    logic [SQ_W-1:0]   sq_bit_reg;
    logic [RT_W-1:0]   ra_reg;
    logic [RT_W-1:0]   rb_reg;
    logic [D_W-1:0]    d_reg;
    logic [D_W-1:0]    rem_reg;
    logic [Q_W-1:0]    q_reg;

    logic              s_vld_reg;
    logic [SLOT_W-1:0] s_slot_reg;
    logic              have_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic signed [VAL_W-1:0] best_sc_reg;

    logic [ID_W-1:0]   out_id_reg;
    logic signed [VAL_W-1:0] out_score_reg;
    logic [RANK_W-1:0] out_rank_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_last_reg;

    // ram read data
    logic signed [VAL_W-1:0] abuf_rdata;
    logic signed [VAL_W-1:0] qbuf_rdata;
    logic signed [VAL_W-1:0] vec_rdata;
    logic signed [VAL_W-1:0] sc_rdata;
    logic [ID_W-1:0]         id_rdata;

    // sweep status
    logic sweep_end;
    logic find_done;
    logic copy_done;
    logic mac_done;
    logic sel_done;
    assign sweep_end = (slot_reg == CNT_W'(N_DOCS));
    assign find_done = sweep_end & ~f_vld_reg;
    assign sel_done  = sweep_end & ~s_vld_reg;
    assign copy_done = (idx_reg == IDXC_W'(DIM)) & ~c_vld_reg;
    assign mac_done  = (idx_reg == IDXC_W'(DIM)) & ~m1_vld_reg & ~m2_vld_reg;

    // effective result count: top_k clamped to 1..K_MAX, then to the fill
    logic [KW-1:0]    k_eff;
    logic [CNT_W-1:0] n_eff;
    always_comb
    begin
        if (top_k_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (top_k_reg > KW'(K_MAX))
        begin
            k_eff = KW'(K_MAX);
        end
        else
        begin
            k_eff = top_k_reg;
        end
        n_eff = (stored_count_reg < CNT_W'(k_eff)) ? stored_count_reg : CNT_W'(k_eff);
    end

    // mac operands
    logic signed [VAL_W-1:0] op_a;
    logic signed [VAL_W-1:0] op_b;
    always_comb
    begin
        op_a = bufv_d_reg ? qbuf_rdata : '0;
        op_b = (state_reg == S_NQ) ? op_a : vec_rdata;
    end

    // isqrt step
    logic [SQ_W-1:0] sq_t;
    logic            sq_ge;
    logic [SQ_W-1:0] sq_x_n;
    logic [SQ_W-1:0] sq_r_n;
    always_comb
    begin
        sq_t   = sq_r_reg + sq_bit_reg;
        sq_ge  = (sq_x_reg >= sq_t);
        sq_x_n = sq_ge ? (sq_x_reg - sq_t) : sq_x_reg;
        sq_r_n = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);
    end

    // divide step
    logic [D_W:0] rem2;
    logic         div_ge;
    always_comb
    begin
        rem2   = {rem_reg, 1'b0};
        div_ge = (rem2 >= {1'b0, d_reg});
    end

    // magnitude of the dot product
    logic [MAG_W-1:0] mag;
    logic             dot_neg;
    logic [DOT_W-1:0] dot_abs;
    always_comb
    begin
        dot_neg = dot_reg[DOT_W-1];
        dot_abs = dot_neg ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
        mag     = dot_abs[MAG_W-1:0];
    end

    // final rounding and saturation
    logic [Q_W:0]            rounded;
    logic signed [VAL_W-1:0] score_fin;
    always_comb
    begin
        rounded = ({1'b0, q_reg} + (Q_W+1)'(1)) >> 1;
        if (nq_zero_reg | nv_zero_reg)
        begin
            score_fin = '0;
        end
        else if (!dot_neg)
        begin
            score_fin = (rounded > (Q_W+1)'(32767)) ? 16'sd32767 : VAL_W'(rounded);
        end
        else
        begin
            score_fin = (rounded > (Q_W+1)'(32768)) ? -16'sd32768 : VAL_W'(-rounded);
        end
    end

    // ranking compare
    logic sel_cand;
    logic sel_better;
    always_comb
    begin
        sel_cand   = slot_valid_reg[s_slot_reg] & ~taken_reg[s_slot_reg];
        sel_better = ~have_reg | (sc_rdata > best_sc_reg) |
                     ((sc_rdata == best_sc_reg) & (id_rdata < best_id_reg));
    end

    logic id_we;
    assign id_we = (state_reg == S_FIND) & find_done & ~hit_found_reg & free_found_reg;

    // memories
    cts_ram #(.WIDTH(VAL_W), .DEPTH(DIM)) u_abuf (
        .clk   (clk),
        .we    (in_acc & (s_axis_tuser == KIND_ADD)),
        .waddr (in_idx),
        .wdata (in_val),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (abuf_rdata)
    );

    cts_ram #(.WIDTH(VAL_W), .DEPTH(DIM)) u_qbuf (
        .clk   (clk),
        .we    (in_acc & (s_axis_tuser == KIND_QUERY)),
        .waddr (in_idx),
        .wdata (in_val),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (qbuf_rdata)
    );

    cts_ram #(.WIDTH(ID_W), .DEPTH(N_DOCS)) u_ids (
        .clk   (clk),
        .we    (id_we),
        .waddr (free_slot_reg),
        .wdata (pend_id_reg),
        .raddr (slot_reg[SLOT_W-1:0]),
        .rdata (id_rdata)
    );

    cts_ram #(.WIDTH(VAL_W), .DEPTH(N_DOCS * DIM)) u_vec (
        .clk   (clk),
        .we    (c_vld_reg),
        .waddr ({tgt_reg, c_idx_reg}),
        .wdata (bufv_d_reg ? abuf_rdata : '0),
        .raddr ({slot_reg[SLOT_W-1:0], idx_reg[IDX_W-1:0]}),
        .rdata (vec_rdata)
    );

    cts_ram #(.WIDTH(VAL_W), .DEPTH(N_DOCS)) u_score (
        .clk   (clk),
        .we    (state_reg == S_WSC),
        .waddr (slot_reg[SLOT_W-1:0]),
        .wdata (score_fin),
        .raddr (slot_reg[SLOT_W-1:0]),
        .rdata (sc_rdata)
    );

    // output beat
    assign m_axis_tvalid = (state_reg == S_EMIT);
    assign m_axis_tdata  = {3'b000, out_rank_reg, out_score_reg, out_id_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            top_k_reg        <= TOPK_RESET;
            slot_valid_reg   <= '0;
            taken_reg        <= '0;
            av_reg           <= '0;
            qv_reg           <= '0;
            stored_count_reg <= '0;
            slot_reg         <= '0;
            idx_reg          <= '0;
            rank_reg         <= '0;
            cyc_reg          <= '0;
            f_vld_reg        <= 1'b0;
            c_vld_reg        <= 1'b0;
            m1_vld_reg       <= 1'b0;
            m2_vld_reg       <= 1'b0;
            s_vld_reg        <= 1'b0;
            hit_found_reg    <= 1'b0;
            free_found_reg   <= 1'b0;
            have_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid & cfg_ready)
            begin
                top_k_reg <= cfg_data;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (s_axis_tuser == KIND_ADD)
                        begin
                            av_reg[in_idx] <= 1'b1;
                        end
                        else if (!s_axis_tlast || stored_count_reg != '0)
                        begin
                            // an empty-store query drops its buffer below
                            qv_reg[in_idx] <= 1'b1;
                        end
                        if (s_axis_tlast)
                        begin
                            idx_reg <= '0;
                            slot_reg <= '0;
                            if (s_axis_tuser == KIND_ADD)
                            begin
                                pend_id_reg    <= in_id;
                                hit_found_reg  <= 1'b0;
                                free_found_reg <= 1'b0;
                                f_vld_reg      <= 1'b0;
                                state_reg      <= S_FIND;
                            end
                            else if (stored_count_reg == '0)
                            begin
                                // empty store: one status beat, buffer dropped
                                qv_reg         <= '0;
                                out_id_reg     <= '0;
                                out_score_reg  <= '0;
                                out_rank_reg   <= '0;
                                out_status_reg <= ST_EMPTY;
                                out_last_reg   <= 1'b1;
                                state_reg      <= S_EMIT;
                            end
                            else
                            begin
                                dot_reg    <= '0;
                                nrm_reg    <= '0;
                                m1_vld_reg <= 1'b0;
                                m2_vld_reg <= 1'b0;
                                state_reg  <= S_NQ;
                            end
                        end
                    end
                end

                S_FIND:
                begin
                    // id sweep: first hit and lowest free slot
                    if (!sweep_end)
                    begin
                        slot_reg   <= slot_reg + 1'b1;
                        f_vld_reg  <= 1'b1;
                        f_slot_reg <= slot_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        f_vld_reg <= 1'b0;
                    end
                    if (f_vld_reg)
                    begin
                        if (slot_valid_reg[f_slot_reg] & (id_rdata == pend_id_reg) &
                            ~hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            tgt_reg       <= f_slot_reg;
                        end
                        if (~slot_valid_reg[f_slot_reg] & ~free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_slot_reg  <= f_slot_reg;
                        end
                    end
                    if (find_done)
                    begin
                        idx_reg   <= '0;
                        c_vld_reg <= 1'b0;
                        if (hit_found_reg)
                        begin
                            state_reg <= S_COPY;
                        end
                        else if (free_found_reg)
                        begin
                            slot_valid_reg[free_slot_reg] <= 1'b1;
                            stored_count_reg <= stored_count_reg + 1'b1;
                            tgt_reg   <= free_slot_reg;
                            state_reg <= S_COPY;
                        end
                        else
                        begin
                            av_reg         <= '0;
                            out_id_reg     <= pend_id_reg;
                            out_score_reg  <= '0;
                            out_rank_reg   <= '0;
                            out_status_reg <= ST_FULL;
                            out_last_reg   <= 1'b1;
                            state_reg      <= S_EMIT;
                        end
                    end
                end

                S_COPY:
                begin
                    if (idx_reg != IDXC_W'(DIM))
                    begin
                        idx_reg    <= idx_reg + 1'b1;
                        c_vld_reg  <= 1'b1;
                        c_idx_reg  <= idx_reg[IDX_W-1:0];
                        bufv_d_reg <= av_reg[idx_reg[IDX_W-1:0]];
                    end
                    else
                    begin
                        c_vld_reg <= 1'b0;
                    end
                    if (copy_done)
                    begin
                        av_reg    <= '0;
                        state_reg <= S_IDLE;
                    end
                end

                S_NQ, S_MAC:
                begin
                    // three-stage mac: read, multiply, accumulate
                    if (idx_reg != IDXC_W'(DIM))
                    begin
                        idx_reg    <= idx_reg + 1'b1;
                        m1_vld_reg <= 1'b1;
                        bufv_d_reg <= qv_reg[idx_reg[IDX_W-1:0]];
                    end
                    else
                    begin
                        m1_vld_reg <= 1'b0;
                    end
                    m2_vld_reg  <= m1_vld_reg;
                    prod_ab_reg <= op_a * op_b;
                    prod_bb_reg <= op_b * op_b;
                    if (m2_vld_reg)
                    begin
                        dot_reg <= dot_reg + DOT_W'(prod_ab_reg);
                        nrm_reg <= nrm_reg + NRM_W'(unsigned'(prod_bb_reg));
                    end
                    if (mac_done)
                    begin
                        sq_x_reg   <= SQ_W'(nrm_reg) << SQ_SHIFT;
                        sq_r_reg   <= '0;
                        sq_bit_reg <= SQ_W'(1) << SQ_TOP;
                        cyc_reg    <= '0;
                        if (state_reg == S_NQ)
                        begin
                            nq_zero_reg <= (nrm_reg == '0);
                            state_reg   <= S_RA;
                        end
                        else
                        begin
                            nv_zero_reg <= (nrm_reg == '0);
                            state_reg   <= S_RB;
                        end
                    end
                end

                S_RA, S_RB:
                begin
                    sq_x_reg   <= sq_x_n;
                    sq_r_reg   <= sq_r_n;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    cyc_reg    <= cyc_reg + 1'b1;
                    if (cyc_reg == CYC_W'(SQ_STEPS - 1))
                    begin
                        if (state_reg == S_RA)
                        begin
                            ra_reg    <= sq_r_n[RT_W-1:0];
                            slot_reg  <= '0;
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            rb_reg    <= sq_r_n[RT_W-1:0];
                            state_reg <= S_MUL;
                        end
                    end
                end

                S_NEXT:
                begin
                    if (sweep_end)
                    begin
                        // scoring finished, start the ranking sweeps
                        qv_reg    <= '0;
                        taken_reg <= '0;
                        rank_reg  <= '0;
                        slot_reg  <= '0;
                        have_reg  <= 1'b0;
                        s_vld_reg <= 1'b0;
                        state_reg <= S_SEL;
                    end
                    else if (slot_valid_reg[slot_reg[SLOT_W-1:0]])
                    begin
                        idx_reg    <= '0;
                        dot_reg    <= '0;
                        nrm_reg    <= '0;
                        m1_vld_reg <= 1'b0;
                        m2_vld_reg <= 1'b0;
                        state_reg  <= S_MAC;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end

                S_MUL:
                begin
                    d_reg     <= D_W'(ra_reg) * D_W'(rb_reg);
                    rem_reg   <= D_W'(mag) << (FRAC_SH - DIV_STEPS);
                    q_reg     <= '0;
                    cyc_reg   <= '0;
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    rem_reg <= div_ge ? D_W'(rem2 - {1'b0, d_reg}) : rem2[D_W-1:0];
                    q_reg   <= {q_reg[Q_W-2:0], div_ge};
                    cyc_reg <= cyc_reg + 1'b1;
                    if (cyc_reg == CYC_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_WSC;
                    end
                end

                S_WSC:
                begin
                    slot_reg  <= slot_reg + 1'b1;
                    state_reg <= S_NEXT;
                end

                S_SEL:
                begin
                    if (!sweep_end)
                    begin
                        slot_reg   <= slot_reg + 1'b1;
                        s_vld_reg  <= 1'b1;
                        s_slot_reg <= slot_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        s_vld_reg <= 1'b0;
                    end
                    if (s_vld_reg & sel_cand & sel_better)
                    begin
                        have_reg      <= 1'b1;
                        best_slot_reg <= s_slot_reg;
                        best_id_reg   <= id_rdata;
                        best_sc_reg   <= sc_rdata;
                    end
                    if (sel_done)
                    begin
                        taken_reg[best_slot_reg] <= 1'b1;
                        out_id_reg     <= best_id_reg;
                        out_score_reg  <= best_sc_reg;
                        out_rank_reg   <= rank_reg[RANK_W-1:0];
                        out_status_reg <= ST_MATCH;
                        out_last_reg   <= (CNT_W'(rank_reg) + 1'b1 == n_eff);
                        state_reg      <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (m_axis_tready)
                    begin
                        rank_reg <= rank_reg + 1'b1;
                        if (out_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            slot_reg  <= '0;
                            have_reg  <= 1'b0;
                            s_vld_reg <= 1'b0;
                            state_reg <= S_SEL;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == 32'(stored_count_reg))
        else $error("stored count disagrees with slot valid bits");

    a_status_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_FULL))
        |-> (m_axis_tlast && m_axis_tdata[52:31] == '0))
        else $error("status beat not a lone final beat");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_MATCH) |-> (CNT_W'(rank_reg) < n_eff))
        else $error("more matches than requested");

endmodule
